// File: sv/tmscan_pkg.sv
// shared types and constants of the timer expiry scan unit
`timescale 1ns / 1ps

package tmscan_pkg;

   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned MASK_W     = 16;
   localparam int unsigned INDEX_W    = 4;
   localparam int unsigned OP_W       = 2;
   localparam int unsigned IDX_CMP_W  = 7;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_SCAN  = 2'd3
   } op_type;

   typedef struct packed {
      logic               running;
      logic               periodic;
      logic [COUNT_W-1:0] period;
      logic [COUNT_W-1:0] start;
   } timer_type;

   typedef struct packed {
      logic      shift;
      logic      load;
      logic      clear;
      timer_type load_value;
   } cell_ctrl_type;

endpackage

// File: sv/tmscan_cell.sv
// one timer slot of the rotating ring
`timescale 1ns / 1ps

module tmscan_cell
   import tmscan_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  timer_type     from_next,
   output timer_type     timer
);

   timer_type timer_ff;
   timer_type timer_in;

   always_comb begin
      timer_in = timer_ff;
      if (ctrl.shift) begin
         timer_in = from_next;
      end else if (ctrl.load) begin
         timer_in = ctrl.load_value;
      end else if (ctrl.clear) begin
         timer_in.running = 1'b0;
         timer_in.start   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
      end else begin
         timer_ff <= timer_in;
      end
   end

   assign timer = timer_ff;

endmodule

// File: sv/tmscan_eval.sv
// expiry check and reload of the timer leaving the head of the ring
`timescale 1ns / 1ps

module tmscan_eval
   import tmscan_pkg::*;
(
   input  timer_type          timer_cur,
   input  logic [COUNT_W-1:0] now,
   output timer_type          timer_upd,
   output logic               fired
);

   logic [COUNT_W-1:0] elapsed;
   logic [COUNT_W-1:0] next_start;

   assign elapsed    = now - timer_cur.start;
   assign next_start = timer_cur.start + timer_cur.period;
   assign fired      = timer_cur.running && (elapsed > timer_cur.period);

   always_comb begin
      timer_upd = timer_cur;
      if (fired) begin
         if (timer_cur.periodic) begin
            timer_upd.start = next_start;
         end else begin
            timer_upd.running = 1'b0;
            timer_upd.start   = '0;
         end
      end
   end

endmodule

// File: sv/multi_timer_expiry_scan_unit.sv
// top level of the timer expiry scan unit
// tick, start and stop beats return nothing
// a scan rotates the ring of NUM_TIMERS cells once, one timer checked per cycle,
// then offers the registered mask as the response from ST_DONE, waiting there while
// the previous response is stalled; the next beat is taken once the state is ST_IDLE again
// synchronous reset clears the counter, every timer and the output valid
`timescale 1ns / 1ps

module multi_timer_expiry_scan_unit
   import tmscan_pkg::*;
#(
   parameter int unsigned NUM_TIMERS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // timer_index [3:0], periodic [4], period [36:5]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op [1:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // fired_mask [15:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned CNT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] tick_ff, tick_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]  rsp_data_ff, rsp_data_in;

   logic               accept;
   op_type             op;
   logic [INDEX_W-1:0] req_index;
   logic               req_periodic;
   logic [COUNT_W-1:0] req_period;
   logic               out_free;

   timer_type          chain [NUM_TIMERS];
   timer_type          eval_out;
   logic               eval_fired;
   timer_type          load_value;

   assign op           = op_type'(req_tuser);
   assign req_index    = req_tdata[3:0];
   assign req_periodic = req_tdata[4];
   assign req_period   = req_tdata[36:5];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign load_value = '{running: 1'b1, periodic: req_periodic,
                         period: req_period, start: tick_ff};

   tmscan_eval u_eval (
      .timer_cur (chain[0]),
      .now       (tick_ff),
      .timer_upd (eval_out),
      .fired     (eval_fired)
   );

   for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
      cell_ctrl_type ctrl;
      timer_type     from_next;
      logic          hit;

      assign hit = (IDX_CMP_W'(req_index) == IDX_CMP_W'(k));
      assign ctrl.shift      = (state_ff == ST_SCAN);
      assign ctrl.load       = accept && (op == OP_START) && hit;
      assign ctrl.clear      = accept && (op == OP_STOP) && hit;
      assign ctrl.load_value = load_value;

      if (k == NUM_TIMERS - 1) begin : g_tail
         assign from_next = eval_out;
      end else begin : g_body
         assign from_next = chain[k+1];
      end

      tmscan_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .from_next (from_next),
         .timer     (chain[k])
      );
   end

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      cnt_in       = cnt_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op == OP_TICK) begin
                  tick_in = tick_ff + COUNT_W'(1);
               end else if (op == OP_SCAN) begin
                  cnt_in   = '0;
                  mask_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            for (int b = 0; b < MASK_W; b++) begin
               if (eval_fired && (IDX_CMP_W'(cnt_ff) == IDX_CMP_W'(b))) begin
                  mask_in[b] = 1'b1;
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_TIMERS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mask_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: tb/sv/tmscan_checker.sv
// checker for the timer expiry scan unit: predicts each fired mask and compares rsp beats
`timescale 1ns / 1ps

module tmscan_checker
   import tmscan_pkg::*;
#(
   parameter int unsigned TIMER_COUNT = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // timer_index [3:0], periodic [4], period [36:5]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op [1:0]
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // fired_mask [15:0]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    error_count,
   output int                    pending_count
);

   logic [COUNT_W-1:0] now_ticks;
   logic [COUNT_W-1:0] armed_period [TIMER_COUNT];
   logic [COUNT_W-1:0] armed_start  [TIMER_COUNT];
   logic               armed        [TIMER_COUNT];
   logic               reloads      [TIMER_COUNT];
   logic [MASK_W-1:0]  expected_masks [$];
   int                 mismatches;

   initial begin
      mismatches = 0;
   end

   function automatic logic [MASK_W-1:0] sweep_timers();
      logic [MASK_W-1:0]  fired;
      logic [COUNT_W-1:0] elapsed;
      fired = '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         if (armed[i]) begin
            elapsed = now_ticks - armed_start[i];
            if (elapsed > armed_period[i]) begin
               if (i < MASK_W) fired[i] = 1'b1;
               if (reloads[i]) begin
                  armed_start[i] = armed_start[i] + armed_period[i];
               end else begin
                  armed[i]       = 1'b0;
                  armed_start[i] = '0;
               end
            end
         end
      end
      return fired;
   endfunction

   task automatic absorb_request(input op_type op, input logic [INDEX_W-1:0] idx,
                                 input logic per, input logic [COUNT_W-1:0] prd);
      case (op)
         OP_TICK: begin
            now_ticks = now_ticks + COUNT_W'(1);
         end
         OP_START: begin
            if (idx < TIMER_COUNT) begin
               reloads[idx]      = per;
               armed_period[idx] = prd;
               armed[idx]        = 1'b1;
               armed_start[idx]  = now_ticks;
            end
         end
         OP_STOP: begin
            if (idx < TIMER_COUNT) begin
               armed[idx]       = 1'b0;
               armed_start[idx] = '0;
            end
         end
         default: begin
            expected_masks.push_back(sweep_timers());
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         now_ticks = '0;
         for (int i = 0; i < TIMER_COUNT; i++) begin
            armed_period[i] = '0;
            armed_start[i]  = '0;
            armed[i]        = 1'b0;
            reloads[i]      = 1'b0;
         end
         expected_masks.delete();
      end else begin
         // result beat first: a scan accepted at this edge cannot answer at it
         if (rsp_tvalid && rsp_tready) begin
            if (expected_masks.size() == 0) begin
               $error("fired_mask: no beat expected, actual %h", rsp_tdata);
               mismatches++;
            end else begin
               if (rsp_tdata[MASK_W-1:0] !== expected_masks[0]) begin
                  $error("fired_mask: expected %h, actual %h", expected_masks[0], rsp_tdata);
                  mismatches++;
               end
               void'(expected_masks.pop_front());
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_request(op_type'(req_tuser), req_tdata[3:0], req_tdata[4], req_tdata[36:5]);
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_masks.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// testbench top of the timer expiry scan unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
   import tmscan_pkg::*;

   localparam int unsigned TIMERS      = 16;
   localparam int unsigned PHASE_ITEMS = 250;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN       = 40;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // timer_index [3:0], periodic [4], period [36:5]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // op [1:0]
   logic [OP_W-1:0]       req_tuser  = OP_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // fired_mask [15:0]
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int error_count;
   int pending_count;
   int idle_pct  = 0;
   int stall_pct = 0;
   int send_quiet = 0;
   int ready_quiet = 0;
   int cycles = 0;
   int op_seen [4] = '{0, 0, 0, 0};

   multi_timer_expiry_scan_unit #(
      .NUM_TIMERS(TIMERS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   tmscan_checker #(
      .TIMER_COUNT(TIMERS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .error_count  (error_count),
      .pending_count(pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d masks outstanding", CYCLE_LIMIT, pending_count);
      $display("DONE: errors detected");
      $finish;
   end

   // receiver backpressure, with occasional stretches of no stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         ready_quiet <= 0;
      end else if (ready_quiet > 0) begin
         rsp_tready  <= 1'b1;
         ready_quiet <= ready_quiet - 1;
      end else begin
         if ($urandom_range(31) == 0) ready_quiet <= $urandom_range(24);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_beat(input op_type op, input logic [INDEX_W-1:0] idx,
                            input logic per, input logic [COUNT_W-1:0] prd);
      if (send_quiet > 0) begin
         send_quiet--;
      end else begin
         if ($urandom_range(31) == 0) send_quiet = $urandom_range(24);
         while ($urandom_range(99) < idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, prd, per, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      op_seen[op]++;
   endtask

   task automatic send_random_beat();
      int                 pick;
      int                 span;
      op_type             op;
      logic [COUNT_W-1:0] prd;
      pick = $urandom_range(99);
      if (pick < 45)      op = OP_TICK;
      else if (pick < 65) op = OP_START;
      else if (pick < 73) op = OP_STOP;
      else                op = OP_SCAN;
      span = $urandom_range(9);
      if (span < 6)       prd = $urandom_range(12);
      else if (span < 8)  prd = $urandom_range(200);
      else if (span == 8) prd = $urandom();
      else                prd = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      send_beat(op, INDEX_W'($urandom_range(15)), 1'($urandom_range(1)), prd);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one-shot and periodic firing, restart, stop, wide periods
      send_beat(OP_SCAN,  4'd0,  1'b0, 32'h0);
      send_beat(OP_START, 4'd0,  1'b0, 32'h0);
      send_beat(OP_SCAN,  4'd0,  1'b0, 32'h0);
      send_beat(OP_TICK,  4'hF,  1'b1, 32'hFFFF_FFFF);
      send_beat(OP_SCAN,  4'd0,  1'b0, 32'h0);
      send_beat(OP_SCAN,  4'hF,  1'b1, 32'hFFFF_FFFF);
      send_beat(OP_START, 4'd15, 1'b1, 32'h0);
      send_beat(OP_START, 4'd1,  1'b1, 32'd2);
      send_beat(OP_START, 4'd2,  1'b0, 32'hFFFF_FFFF);
      repeat (3) send_beat(OP_TICK, 4'd0, 1'b0, 32'h0);
      send_beat(OP_SCAN,  4'd0,  1'b0, 32'h0);
      send_beat(OP_SCAN,  4'd0,  1'b0, 32'h0);
      send_beat(OP_START, 4'd1,  1'b0, 32'd1);
      send_beat(OP_STOP,  4'd15, 1'b1, 32'hFFFF_FFFF);
      send_beat(OP_TICK,  4'd0,  1'b0, 32'h0);
      send_beat(OP_TICK,  4'd0,  1'b0, 32'h0);
      send_beat(OP_SCAN,  4'd0,  1'b0, 32'h0);
      send_beat(OP_STOP,  4'd2,  1'b0, 32'h0);
      send_beat(OP_STOP,  4'd0,  1'b0, 32'h0);
      send_beat(OP_START, 4'd7,  1'b1, 32'h8000_0000);
      send_beat(OP_TICK,  4'd0,  1'b0, 32'h0);
      send_beat(OP_SCAN,  4'd0,  1'b0, 32'h0);

      // random phases: no idling, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct <= 0;  stall_pct <= 0;  end
            1: begin idle_pct <= 86; stall_pct <= 0;  end
            2: begin idle_pct <= 0;  stall_pct <= 86; end
            default: begin idle_pct <= 30; stall_pct <= 30; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_beat();
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("covered %0d tick, %0d start, %0d stop and %0d scan beats in %0d cycles",
               op_seen[OP_TICK], op_seen[OP_START], op_seen[OP_STOP], op_seen[OP_SCAN], cycles);
      $display("phases: free flow, sender idle 86%%, receiver stall 86%%, both 30%%");
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
